// ----- hw/rtl/vtg_pkg.sv -----
// ----------------------------------------------------------------------------
// vtg_pkg: shared types and constants of the vbap triangle gain block
// Payload structs, queue entry, register codes and fixed-point widths.
// ----------------------------------------------------------------------------
package vtg_pkg;

    localparam int DIR_W   = 16;
    localparam int MAT_W   = 24;
    localparam int IDX_W   = 13;
    localparam int GAIN_W  = 17;
    localparam int PROD_W  = 40;
    localparam int G_W     = 42;
    localparam int MAG_W   = 40;
    localparam int HALF_W  = 20;
    localparam int SQ_W    = 80;
    localparam int S_W     = 82;
    localparam int SMALL_W = 18;
    localparam int T_W     = 36;
    localparam int CMP_W   = 83;
    localparam int SUM_W   = 42;
    localparam int NUM_W   = 58;
    localparam int FRAC_W  = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [1:0] REG_VERTEX_A   = 2'd0;
    localparam logic [1:0] REG_VERTEX_B   = 2'd1;
    localparam logic [1:0] REG_VERTEX_C   = 2'd2;
    localparam logic [1:0] REG_MEAS_COUNT = 2'd3;

    // -0.001 in 2^-30 units
    localparam logic signed [G_W-1:0] INSIDE_LIMIT = -42'sd1073742;

    // 1e14 = (1e7)^2, split for two narrow multiplies
    localparam logic [46:0] KEEP_SQ   = 47'd100000000000000;
    localparam int          KEEP_LO_W = 24;
    localparam logic [KEEP_LO_W-1:0] KEEP_LO = KEEP_SQ[KEEP_LO_W-1:0];
    localparam logic [46-KEEP_LO_W:0] KEEP_HI = KEEP_SQ[46:KEEP_LO_W];

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

    typedef logic signed [G_W-1:0] graw_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic signed [MAT_W-1:0] mat_00;
        logic signed [MAT_W-1:0] mat_01;
        logic signed [MAT_W-1:0] mat_02;
        logic signed [MAT_W-1:0] mat_10;
        logic signed [MAT_W-1:0] mat_11;
        logic signed [MAT_W-1:0] mat_12;
        logic signed [MAT_W-1:0] mat_20;
        logic signed [MAT_W-1:0] mat_21;
        logic signed [MAT_W-1:0] mat_22;
    } in_item_t;

    typedef struct packed {
        logic              inside_res;
        logic [1:0]        used_count;
        logic [IDX_W-1:0]  out_index_0;
        logic [GAIN_W-1:0] out_gain_0;
        logic [IDX_W-1:0]  out_index_1;
        logic [GAIN_W-1:0] out_gain_1;
        logic [IDX_W-1:0]  out_index_2;
        logic [GAIN_W-1:0] out_gain_2;
    } out_item_t;

    typedef struct packed {
        logic  in_tri;
        graw_t g0;
        graw_t g1;
        graw_t g2;
    } q_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
        logic [IDX_W-1:0] idx_c;
        logic [IDX_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- hw/rtl/vtg_front.sv -----
// ----------------------------------------------------------------------------
// vtg_front: dot products and inside test
// Two stages: nine products, then three row sums checked against the limit.
// ----------------------------------------------------------------------------
module vtg_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vtg_pkg::in_item_t  s_data,
    input  vtg_pkg::q_status_t q_status,
    output logic               q_push,
    output vtg_pkg::q_item_t   q_data
);
    import vtg_pkg::*;

    logic                     ce;
    logic                     f1_valid_reg;
    logic                     f2_valid_reg;
    logic signed [PROD_W-1:0] prod_reg [9];
    logic signed [PROD_W-1:0] prod_next [9];
    logic signed [MAT_W-1:0]  mat [9];
    logic signed [DIR_W-1:0]  dir [3];
    graw_t                    g_next [3];
    q_item_t                  item_reg;
    q_item_t                  item_next;

    // stall only when the last stage cannot enter the queue
    assign ce      = !(f2_valid_reg && q_status.full);
    assign s_ready = ce;
    assign q_push  = f2_valid_reg && !q_status.full;
    assign q_data  = item_reg;

    // operand unpacking and products
    always_comb begin
        dir[0] = s_data.dir_x;
        dir[1] = s_data.dir_y;
        dir[2] = s_data.dir_z;
        mat[0] = s_data.mat_00;
        mat[1] = s_data.mat_01;
        mat[2] = s_data.mat_02;
        mat[3] = s_data.mat_10;
        mat[4] = s_data.mat_11;
        mat[5] = s_data.mat_12;
        mat[6] = s_data.mat_20;
        mat[7] = s_data.mat_21;
        mat[8] = s_data.mat_22;
        for (int i = 0; i < 9; i++) begin
            prod_next[i] = PROD_W'(mat[i] * dir[i % 3]);
        end
    end

    // row sums and inside test
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            g_next[r] = G_W'(prod_reg[3*r]) + G_W'(prod_reg[3*r+1]) + G_W'(prod_reg[3*r+2]);
        end
        item_next.g0     = g_next[0];
        item_next.g1     = g_next[1];
        item_next.g2     = g_next[2];
        item_next.in_tri = (g_next[0] > INSIDE_LIMIT) && (g_next[1] > INSIDE_LIMIT)
                           && (g_next[2] > INSIDE_LIMIT);
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else if (ce) begin
            f1_valid_reg <= s_valid;
            f2_valid_reg <= f1_valid_reg;
        end
        if (ce) begin
            prod_reg <= prod_next;
            item_reg <= item_next;
        end
    end

endmodule

// ----- hw/rtl/vtg_queue.sv -----
// ----------------------------------------------------------------------------
// vtg_queue: small queue between front and back
// Register-based fifo; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module vtg_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  vtg_pkg::q_item_t   push_data,
    input  logic               pop,
    output vtg_pkg::q_item_t   head,
    output vtg_pkg::q_status_t status
);
    import vtg_pkg::*;

    q_item_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/vtg_back.sv -----
// ----------------------------------------------------------------------------
// vtg_back: keep test, ordering and gain division
// Squares and norm compare, vertex sort and compaction, then a 17-stage
// restoring divider per slot and the output register.
// ----------------------------------------------------------------------------
module vtg_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  vtg_pkg::cfg_t      cfg,
    input  vtg_pkg::q_item_t   q_head,
    input  vtg_pkg::q_status_t q_status,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output vtg_pkg::out_item_t m_data
);
    import vtg_pkg::*;

    localparam int DIV_STAGES = GAIN_W;

    typedef struct packed {
        logic                        in_tri;
        logic [1:0]                  used;
        logic [2:0][IDX_W-1:0]       idx;
        logic [SUM_W-1:0]            sum;
        logic [2:0][NUM_W-1:0]       rem;
        logic [2:0][GAIN_W-1:0]      quo;
    } div_t;

    logic ce;
    logic b1_valid_reg, b2_valid_reg, b3_valid_reg, b4_valid_reg, b5_valid_reg;
    logic [DIV_STAGES:0] dv_reg;
    logic out_valid_reg;

    // stage 1: magnitudes and partial products
    graw_t             gq [3];
    logic              b1_inside_reg;
    logic [MAG_W-1:0]  b1_mag_reg [3];
    logic [MAG_W-1:0]  b1_ll_reg [3], b1_lh_reg [3], b1_hh_reg [3];
    logic [T_W-1:0]    b1_t_reg [3];
    logic              b1_pos_reg [3], b1_big_reg [3];
    // stage 2
    logic              b2_inside_reg;
    logic [MAG_W-1:0]  b2_mag_reg [3];
    logic [SQ_W-1:0]   b2_sq_reg [3];
    logic [T_W+KEEP_LO_W-1:0] b2_pl_reg [3];
    logic [T_W+47-KEEP_LO_W-1:0] b2_ph_reg [3];
    logic              b2_pos_reg [3], b2_big_reg [3];
    // stage 3
    logic              b3_inside_reg;
    logic [MAG_W-1:0]  b3_mag_reg [3];
    logic [S_W-1:0]    b3_s_reg;
    logic [CMP_W-1:0]  b3_q_reg [3];
    logic              b3_pos_reg [3], b3_big_reg [3];
    // stage 4
    logic              b4_inside_reg;
    logic [MAG_W-1:0]  b4_mag_reg [3];
    logic [2:0]        b4_keep_reg;
    logic [IDX_W-1:0]  vidx [3];
    // stage 5: compacted slots
    logic              b5_inside_reg;
    logic [1:0]        b5_used_reg;
    logic [2:0][IDX_W-1:0] b5_idx_reg;
    logic [MAG_W-1:0]  b5_g_reg [3];
    logic [SUM_W-1:0]  b5_sum_reg;
    logic [1:0]        rank [3];
    logic [1:0]        slot [3];
    logic [1:0]        used_next;
    logic [2:0][IDX_W-1:0] sidx_next;
    logic [MAG_W-1:0]  sg_next [3];
    logic [SUM_W-1:0]  sum_next;
    // divider chain, entry 0 holds the numerators
    div_t              d_reg [DIV_STAGES+1];
    div_t              d_next [DIV_STAGES+1];
    out_item_t         out_reg;
    out_item_t         out_next;

    assign ce      = !out_valid_reg || m_ready;
    assign q_pop   = ce && !q_status.empty;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign gq[0] = q_head.g0;
    assign gq[1] = q_head.g1;
    assign gq[2] = q_head.g2;
    assign vidx[0] = cfg.idx_a;
    assign vidx[1] = cfg.idx_b;
    assign vidx[2] = cfg.idx_c;

    // stable ascending ranks of the three vertex indexes
    always_comb begin
        rank[0] = 2'(vidx[1] < vidx[0]) + 2'(vidx[2] < vidx[0]);
        rank[1] = 2'(vidx[0] <= vidx[1]) + 2'(vidx[2] < vidx[1]);
        rank[2] = 2'(vidx[0] <= vidx[2]) + 2'(vidx[1] <= vidx[2]);
    end

    // slot of each kept vertex and compaction
    always_comb begin
        used_next = 2'd0;
        sum_next  = '0;
        for (int k = 0; k < 3; k++) begin
            slot[k] = 2'd0;
            for (int j = 0; j < 3; j++) begin
                if (j != k && b4_keep_reg[j] && rank[j] < rank[k]) begin
                    slot[k] = slot[k] + 2'd1;
                end
            end
            if (b4_keep_reg[k]) begin
                used_next = used_next + 2'd1;
                sum_next  = sum_next + SUM_W'(b4_mag_reg[k]);
            end
        end
        for (int s = 0; s < 3; s++) begin
            sidx_next[s] = '0;
            sg_next[s]   = '0;
            for (int k = 0; k < 3; k++) begin
                if (b4_keep_reg[k] && slot[k] == 2'(s)) begin
                    sidx_next[s] = vidx[k];
                    sg_next[s]   = b4_mag_reg[k];
                end
            end
        end
    end

    // data registers of the back pipeline
    always_ff @(posedge aclk) begin
        if (ce) begin
            // stage 1
            b1_inside_reg <= q_head.in_tri;
            for (int k = 0; k < 3; k++) begin
                logic [G_W-1:0]    neg;
                logic [MAG_W-1:0]  mag;
                logic [HALF_W-1:0] lo, hi;
                neg = -gq[k];
                mag = gq[k][G_W-1] ? neg[MAG_W-1:0] : gq[k][MAG_W-1:0];
                lo  = mag[HALF_W-1:0];
                hi  = mag[MAG_W-1:HALF_W];
                b1_mag_reg[k] <= mag;
                b1_ll_reg[k]  <= MAG_W'(lo * lo);
                b1_lh_reg[k]  <= MAG_W'(lo * hi);
                b1_hh_reg[k]  <= MAG_W'(hi * hi);
                b1_t_reg[k]   <= T_W'(gq[k][SMALL_W-1:0] * gq[k][SMALL_W-1:0]);
                b1_pos_reg[k] <= !gq[k][G_W-1] && (gq[k] != '0);
                b1_big_reg[k] <= !gq[k][G_W-1] && (|gq[k][G_W-2:SMALL_W]);
            end
            // stage 2
            b2_inside_reg <= b1_inside_reg;
            for (int k = 0; k < 3; k++) begin
                b2_mag_reg[k] <= b1_mag_reg[k];
                b2_sq_reg[k]  <= (SQ_W'(b1_hh_reg[k]) << (2*HALF_W))
                                 + (SQ_W'(b1_lh_reg[k]) << (HALF_W+1))
                                 + SQ_W'(b1_ll_reg[k]);
                b2_pl_reg[k]  <= (T_W+KEEP_LO_W)'(b1_t_reg[k] * KEEP_LO);
                b2_ph_reg[k]  <= (T_W+47-KEEP_LO_W)'(b1_t_reg[k] * KEEP_HI);
                b2_pos_reg[k] <= b1_pos_reg[k];
                b2_big_reg[k] <= b1_big_reg[k];
            end
            // stage 3: squared norm and scaled small gain
            b3_inside_reg <= b2_inside_reg;
            b3_s_reg      <= S_W'(b2_sq_reg[0]) + S_W'(b2_sq_reg[1]) + S_W'(b2_sq_reg[2]);
            for (int k = 0; k < 3; k++) begin
                b3_mag_reg[k] <= b2_mag_reg[k];
                b3_q_reg[k]   <= (CMP_W'(b2_ph_reg[k]) << KEEP_LO_W) + CMP_W'(b2_pl_reg[k]);
                b3_pos_reg[k] <= b2_pos_reg[k];
                b3_big_reg[k] <= b2_big_reg[k];
            end
            // stage 4: keep decision
            b4_inside_reg <= b3_inside_reg;
            for (int k = 0; k < 3; k++) begin
                b4_mag_reg[k]  <= b3_mag_reg[k];
                b4_keep_reg[k] <= b3_inside_reg && b3_pos_reg[k] && (vidx[k] < cfg.limit)
                                  && (b3_big_reg[k] || (b3_q_reg[k] > CMP_W'(b3_s_reg)));
            end
            // stage 5: ordered slots
            b5_inside_reg <= b4_inside_reg;
            b5_used_reg   <= used_next;
            b5_idx_reg    <= sidx_next;
            b5_g_reg      <= sg_next;
            b5_sum_reg    <= sum_next;
            // divider chain and output
            d_reg   <= d_next;
            out_reg <= out_next;
        end
    end

    // numerators: gain scaled by 2^16 plus half the sum
    always_comb begin
        d_next[0].in_tri = b5_inside_reg;
        d_next[0].used   = b5_used_reg;
        d_next[0].idx    = b5_idx_reg;
        d_next[0].sum    = b5_sum_reg;
        d_next[0].quo    = '0;
        for (int s = 0; s < 3; s++) begin
            d_next[0].rem[s] = (NUM_W'(b5_g_reg[s]) << FRAC_W) + NUM_W'(b5_sum_reg >> 1);
        end
    end

    // one quotient bit per stage
    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        localparam int QB = DIV_STAGES - 1 - i;
        always_comb begin
            logic [NUM_W-1:0] dsh;
            dsh = NUM_W'(d_reg[i].sum) << QB;
            d_next[i+1] = d_reg[i];
            for (int s = 0; s < 3; s++) begin
                if (d_reg[i].rem[s] >= dsh) begin
                    d_next[i+1].rem[s]     = d_reg[i].rem[s] - dsh;
                    d_next[i+1].quo[s][QB] = 1'b1;
                end
            end
        end
    end

    // result assembly, unused slots read zero
    always_comb begin
        div_t last;
        last = d_reg[DIV_STAGES];
        out_next.inside_res  = last.in_tri;
        out_next.used_count  = last.used;
        out_next.out_index_0 = (last.used > 2'd0) ? last.idx[0] : '0;
        out_next.out_gain_0  = (last.used > 2'd0) ? last.quo[0] : '0;
        out_next.out_index_1 = (last.used > 2'd1) ? last.idx[1] : '0;
        out_next.out_gain_1  = (last.used > 2'd1) ? last.quo[1] : '0;
        out_next.out_index_2 = (last.used > 2'd2) ? last.idx[2] : '0;
        out_next.out_gain_2  = (last.used > 2'd2) ? last.quo[2] : '0;
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            b5_valid_reg  <= 1'b0;
            dv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            b1_valid_reg  <= q_pop;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            b4_valid_reg  <= b3_valid_reg;
            b5_valid_reg  <= b4_valid_reg;
            dv_reg        <= {dv_reg[DIV_STAGES-1:0], b5_valid_reg};
            out_valid_reg <= dv_reg[DIV_STAGES];
        end
    end

    // an outside result carries no vertices
    a_outside_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.inside_res |-> m_data.used_count == 2'd0
            && m_data.out_gain_0 == '0 && m_data.out_index_0 == '0)
        else $error("outside result carries vertices");

    // a single kept vertex takes the whole gain
    a_single_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.used_count == 2'd1 |-> m_data.out_gain_0 == GAIN_ONE)
        else $error("single vertex gain is not one");

    // the first two kept slots come out in ascending index order
    a_ascending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.used_count >= 2'd2 |-> m_data.out_index_0 <= m_data.out_index_1)
        else $error("slot indexes out of order");

    // a stalled result is not overwritten
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

// ----- hw/rtl/vbap_triangle_gain_core.sv -----
// ----------------------------------------------------------------------------
// vbap_triangle_gain_core: vbap gains of one triangle for a stream of directions
// Top level with configuration registers, front, queue and back.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: a direction (Q1.14) and the triangle's inverse matrix (Q7.16),
//   one request per valid/ready handshake.
//   m_ channel: inside flag, number of kept vertices and up to three
//   index/gain pairs in ascending index order, gains Q1.16 of their sum.
//   cfg_we/cfg_index/cfg_wdata write the three vertex indexes and the
//   measurement count; write them only while no request is in flight.
//   Path from acceptance to m_valid: two front stages, the queue entry,
//   six back stages, 17 divider stages and the output register.
//   Throughput: one request per cycle while m_ready does not stall, set by the fully pipelined divider.
//   Reset clears all valid flags and the queue and loads the register
//   defaults (indexes 0, measurement count 4).
//   A stall on m_ready freezes the back pipeline; the four-entry queue
//   absorbs the front until it is full, then s_ready drops.
// ----------------------------------------------------------------------------
module vbap_triangle_gain_core #(
    parameter int MAX_MEASUREMENTS = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vtg_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output vtg_pkg::out_item_t m_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_wdata
);
    import vtg_pkg::*;

    localparam logic [IDX_W-1:0] MAX_LIMIT = IDX_W'(MAX_MEASUREMENTS);

    logic [IDX_W-1:0] idx_a_reg, idx_b_reg, idx_c_reg, count_reg;
    cfg_t             cfg;
    logic             q_push;
    logic             q_pop;
    q_item_t          q_data;
    q_item_t          q_head;
    q_status_t        q_status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_a_reg <= '0;
            idx_b_reg <= '0;
            idx_c_reg <= '0;
            count_reg <= IDX_W'(4);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_VERTEX_A:   idx_a_reg <= cfg_wdata;
                REG_VERTEX_B:   idx_b_reg <= cfg_wdata;
                REG_VERTEX_C:   idx_c_reg <= cfg_wdata;
                REG_MEAS_COUNT: count_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // dummy limit is the smaller of count and the build maximum
    always_comb begin
        cfg.idx_a = idx_a_reg;
        cfg.idx_b = idx_b_reg;
        cfg.idx_c = idx_c_reg;
        cfg.limit = (count_reg < MAX_LIMIT) ? count_reg : MAX_LIMIT;
    end

    vtg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    vtg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    vtg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_head   (q_head),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- sim/vbap_triangle_gain_core_test.sv -----
// ----------------------------------------------------------------------------
// vbap_triangle_gain_core_test: self-checking bench of the vbap gain core
// Directed and random directions and matrices under several register settings,
// with random idling on both channels; each result is checked field by field
// against a predicted gain set.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vbap_triangle_gain_core_test;
    import vtg_pkg::*;

    localparam int MAX_MEAS  = 4096;
    localparam int CYCLE_MAX = 400000;
    localparam int EXP_DEPTH = 2048;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_wdata;

    // predictor copy of the registers
    logic [12:0] vtx_a, vtx_b, vtx_c, meas_count;

    // expected results in send order
    out_item_t expected_gains [EXP_DEPTH];
    int        exp_wr_count;
    int        exp_rd_count;
    int        error_count;
    int        cycle_count;

    vbap_triangle_gain_core #(.MAX_MEASUREMENTS(MAX_MEAS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX) begin
            $display("vbap_triangle_gain_core: mismatch");
            $finish;
        end
    end

    // gain prediction for one request
    function automatic out_item_t predict_gains(in_item_t req);
        out_item_t r;
        logic signed [63:0] d[3];
        logic signed [63:0] m[9];
        logic signed [63:0] g[3];
        logic [12:0] ix[3];
        int ord[3];
        int t, j, k, used;
        logic [127:0] norm_sq, keep_sq;
        logic [63:0] lim, sum;
        logic [63:0] kg[3];
        logic [12:0] ki[3];
        logic [63:0] q;
        r = '0;
        d[0] = req.dir_x; d[1] = req.dir_y; d[2] = req.dir_z;
        m[0] = req.mat_00; m[1] = req.mat_01; m[2] = req.mat_02;
        m[3] = req.mat_10; m[4] = req.mat_11; m[5] = req.mat_12;
        m[6] = req.mat_20; m[7] = req.mat_21; m[8] = req.mat_22;
        for (int i = 0; i < 3; i++) begin
            g[i] = m[3*i]*d[0] + m[3*i+1]*d[1] + m[3*i+2]*d[2];
            if (!(g[i] > -64'sd1073742)) return r;
        end
        r.inside_res = 1'b1;
        // exact squares (magnitudes fit 42 bits, squares fit 84)
        norm_sq = '0;
        for (int i = 0; i < 3; i++) begin
            logic [127:0] a;
            a = g[i] < 0 ? 128'(-g[i]) : 128'(g[i]);
            norm_sq += a * a;
        end
        ix[0] = vtx_a; ix[1] = vtx_b; ix[2] = vtx_c;
        ord[0] = 0; ord[1] = 1; ord[2] = 2;
        // stable insertion sort by index
        for (int i = 1; i < 3; i++) begin
            t = ord[i];
            j = i;
            while (j > 0 && ix[ord[j-1]] > ix[t]) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = t;
        end
        lim = (meas_count < MAX_MEAS) ? 64'(meas_count) : 64'(MAX_MEAS);
        used = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            k = ord[i];
            if (64'(ix[k]) >= lim || g[k] <= 0) continue;
            keep_sq = 128'(g[k]) * 128'(g[k]) * 128'd100000000000000;
            if (keep_sq > norm_sq) begin
                ki[used] = ix[k];
                kg[used] = g[k];
                sum += g[k];
                used++;
            end
        end
        r.used_count = used[1:0];
        for (int i = 0; i < used; i++) begin
            q = ((kg[i] << 16) + sum / 2) / sum;
            case (i)
                0: begin r.out_index_0 = ki[i]; r.out_gain_0 = q[16:0]; end
                1: begin r.out_index_1 = ki[i]; r.out_gain_1 = q[16:0]; end
                default: begin r.out_index_2 = ki[i]; r.out_gain_2 = q[16:0]; end
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("error: %s got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // result checker with random stall
    initial begin
        out_item_t want;
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            @(negedge aclk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0) stall = 0;
            m_ready = 1'b0;
            repeat (stall) @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            if (exp_rd_count == exp_wr_count) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = expected_gains[exp_rd_count];
                exp_rd_count++;
                if (m_data.inside_res !== want.inside_res)
                    report_mismatch("inside_res", m_data.inside_res, want.inside_res);
                if (m_data.used_count !== want.used_count)
                    report_mismatch("used_count", m_data.used_count, want.used_count);
                if (m_data.out_index_0 !== want.out_index_0)
                    report_mismatch("out_index_0", m_data.out_index_0, want.out_index_0);
                if (m_data.out_gain_0 !== want.out_gain_0)
                    report_mismatch("out_gain_0", m_data.out_gain_0, want.out_gain_0);
                if (m_data.out_index_1 !== want.out_index_1)
                    report_mismatch("out_index_1", m_data.out_index_1, want.out_index_1);
                if (m_data.out_gain_1 !== want.out_gain_1)
                    report_mismatch("out_gain_1", m_data.out_gain_1, want.out_gain_1);
                if (m_data.out_index_2 !== want.out_index_2)
                    report_mismatch("out_index_2", m_data.out_index_2, want.out_index_2);
                if (m_data.out_gain_2 !== want.out_gain_2)
                    report_mismatch("out_gain_2", m_data.out_gain_2, want.out_gain_2);
            end
        end
    end

    // send one request, after a random gap
    task automatic send_request(in_item_t req);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        expected_gains[exp_wr_count] = predict_gains(req);
        exp_wr_count++;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (exp_rd_count != exp_wr_count) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [12:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_VERTEX_A: vtx_a = val;
            REG_VERTEX_B: vtx_b = val;
            REG_VERTEX_C: vtx_c = val;
            default:      meas_count = val;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_triangle(logic [12:0] a, logic [12:0] b, logic [12:0] c,
                                logic [12:0] n);
        write_register(REG_VERTEX_A, a);
        write_register(REG_VERTEX_B, b);
        write_register(REG_VERTEX_C, c);
        write_register(REG_MEAS_COUNT, n);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic signed [23:0] rand_mat();
        case ($urandom_range(0, 7))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'($urandom);
            3: return 24'($signed($urandom_range(0, 2000)) - 1000);
            default: return 24'($signed($urandom_range(0, 262144)) - 65536);
        endcase
    endfunction

    function automatic in_item_t rand_request();
        in_item_t r;
        r.dir_x = rand_dir(); r.dir_y = rand_dir(); r.dir_z = rand_dir();
        r.mat_00 = rand_mat(); r.mat_01 = rand_mat(); r.mat_02 = rand_mat();
        r.mat_10 = rand_mat(); r.mat_11 = rand_mat(); r.mat_12 = rand_mat();
        r.mat_20 = rand_mat(); r.mat_21 = rand_mat(); r.mat_22 = rand_mat();
        return r;
    endfunction

    // request whose gains are mostly inside: identity-like matrix, non-negative dir
    function automatic in_item_t inside_request();
        in_item_t r;
        r = rand_request();
        r.dir_x = 16'($urandom_range(0, 16384));
        r.dir_y = 16'($urandom_range(0, 16384));
        r.dir_z = 16'($urandom_range(0, 16384));
        r.mat_00 = 24'($urandom_range(0, 131072)); r.mat_11 = 24'($urandom_range(0, 131072));
        r.mat_22 = 24'($urandom_range(0, 131072));
        r.mat_01 = 24'($signed($urandom_range(0, 400)) - 200);
        r.mat_02 = 24'($signed($urandom_range(0, 400)) - 200);
        r.mat_10 = 24'($signed($urandom_range(0, 400)) - 200);
        r.mat_12 = 24'($signed($urandom_range(0, 400)) - 200);
        r.mat_20 = 24'($signed($urandom_range(0, 400)) - 200);
        r.mat_21 = 24'($signed($urandom_range(0, 400)) - 200);
        if ($urandom_range(0, 5) == 0) r.dir_y = 16'd0;
        return r;
    endfunction

    task automatic diag(int a, int b, int c, int x, int y, int z);
        in_item_t r;
        r = '0;
        r.mat_00 = 24'(a); r.mat_11 = 24'(b); r.mat_22 = 24'(c);
        r.dir_x = 16'(x); r.dir_y = 16'(y); r.dir_z = 16'(z);
        send_request(r);
    endtask

    // extremes, outside, boundary, zero gains, negligible gain, single vertex
    task automatic test_directed();
        in_item_t r;
        set_triangle(13'd1, 13'd2, 13'd3, 13'd4);
        diag(65536, 65536, 65536, 16384, 16384, 16384);
        diag(65536, 65536, 65536, 0, 0, 0);
        diag(65536, 65536, 65536, 16384, 0, 0);
        diag(65536, 65536, 65536, -16384, 16384, 16384);
        // small negative first gains, both above the outside limit
        diag(1, 65536, 65536, -1073742, 100, 100);
        diag(1, 65536, 65536, -16, 100, 100);
        r = '0; r.mat_00 = 24'sd65536; r.mat_01 = -24'sd66; r.dir_x = 16'sd16384;
        r.dir_y = 16'sd16384; r.mat_11 = 24'sd65536; r.mat_22 = 24'sd65536;
        r.dir_z = 16'sd1;
        send_request(r);
        // negligible tiny gain beside a large gain, at two scales
        diag(1, 65536, 65536, 1, 16384, 0);
        diag(1, 8191, 0, 1, 16384, 0);
        r = '1; send_request(r);
        r = '0; send_request(r);
        r.dir_x = 16'h8000; r.dir_y = 16'h7fff; r.dir_z = 16'h8000;
        r.mat_00 = 24'h800000; r.mat_01 = 24'h7fffff; r.mat_02 = 24'h800000;
        r.mat_10 = 24'h7fffff; r.mat_11 = 24'h800000; r.mat_12 = 24'h7fffff;
        r.mat_20 = 24'h800000; r.mat_21 = 24'h7fffff; r.mat_22 = 24'h800000;
        send_request(r);
        diag(3, 5, 7, 16384, 16384, 16384);
        drain_pipeline();
        // equal and unsorted indexes, two dummies
        set_triangle(13'd3, 13'd3, 13'd0, 13'd3);
        diag(65536, 131072, 196608, 16384, 16384, 16384);
        diag(-65536, 131072, 196608, 16384, 16384, 16384);
        drain_pipeline();
        // measurement count out of range and max indexes
        set_triangle(13'h1fff, 13'd4095, 13'd4096, 13'h1fff);
        diag(65536, 131072, 196608, 16384, 16384, 16384);
        drain_pipeline();
        set_triangle(13'd0, 13'd0, 13'd0, 13'd0);
        diag(65536, 131072, 196608, 16384, 16384, 16384);
        drain_pipeline();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_request(($urandom_range(0, 3) == 0) ? rand_request() : inside_request());
        drain_pipeline();
    endtask

    task automatic test_settings();
        set_triangle(13'd7, 13'd2, 13'd5, 13'd8);
        test_random(150);
        set_triangle(13'h1fff, 13'd0, 13'd4095, 13'd4096);
        test_random(150);
        set_triangle(13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
        test_random(100);
        set_triangle(13'd1, 13'd1, 13'd1, 13'd4);
        test_random(100);
        set_triangle(13'd0, 13'd2, 13'd1, 13'd4);
        test_random(100);
    endtask

    initial begin
        error_count  = 0;
        cycle_count  = 0;
        exp_wr_count = 0;
        exp_rd_count = 0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_VERTEX_A;
        cfg_wdata = '0;
        vtx_a = 0; vtx_b = 0; vtx_c = 0; meas_count = 13'd4;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_settings();
        if (error_count == 0)
            $display("vbap_triangle_gain_core: match");
        else
            $display("vbap_triangle_gain_core: mismatch");
        $finish;
    end

endmodule
